// ===== design/occ_pkg.sv =====
`default_nettype none

package occ_pkg;

	// grid geometry and counter size
	localparam int GRID_WIDTH  = 512;
	localparam int GRID_HEIGHT = 512;
	localparam int COUNT_BITS  = 16;

	localparam int CELL_TOTAL = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W     = (CELL_TOTAL > 1) ? $clog2(CELL_TOTAL) : 1;

	// fixed field widths
	localparam int OP_W      = 2;
	localparam int COORD_W   = 12;
	localparam int CFG_W     = 10;
	localparam int VAL_W     = 10;
	localparam int OUT_CNT_W = 16;

	// APB
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// score = SCORE_SCALE*hits/(hits+misses) - SCORE_OFFSET
	localparam int SCORE_SCALE  = 600;
	localparam int SCORE_OFFSET = 300;
	localparam int Q_W          = 10;                 // quotient never above 600
	localparam int NUM_W        = COUNT_BITS + Q_W;   // 600*hits
	localparam int DEN_W        = COUNT_BITS + 1;     // hits+misses
	localparam int STEP_W       = $clog2(Q_W);

	localparam logic [OP_W-1:0] OP_MISS = 2'd0;
	localparam logic [OP_W-1:0] OP_HIT  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic REG_MAP_WIDTH  = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;

	localparam logic [CFG_W-1:0] MAP_DIM_RESET = 10'd512;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MODIFY,
		ST_MULT,
		ST_DIVINIT,
		ST_DIV
	} occ_state_t;

	typedef struct packed {
		logic clear;     // write zero at sweep address, advance sweep
		logic load;      // capture op and cell address
		logic rd;        // read counter word
		logic modify;    // bump and write back
		logic mult;      // form numerator and denominator
		logic div_init;  // seed divider
		logic div_step;  // one quotient bit
		logic finish;    // last quotient bit, launch result
	} occ_cmd_t;

	typedef struct packed {
		logic in_range;
		logic clr_last;
	} occ_status_t;

endpackage

`default_nettype wire

// ===== design/occupancy_grid_hit_miss_counter.sv =====
// Sequence: an accepted item steps through read, modify, multiply, divider seed and the serial divide.
//   done is high for one cycle, and busy is already low in that cycle.
// A new in-map transaction is taken only once the last is through; out-of-map items give no result.
// Cost per item is set by the counter read-modify-write and a 10-step serial divider.
// Reset: async, active low; after release the counter stores are swept to zero
//   with busy high (APB writes still taken). Results cannot be stalled.
`default_nettype none

module occupancy_grid_hit_miss_counter
	import occ_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// APB configuration port
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic        [PADDR_W-1:0]   paddr,
	input  wire logic        [PDATA_W-1:0]   pwdata,
	output logic             [PDATA_W-1:0]   prdata,
	output logic                             pready,
	// command side
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic        [OP_W-1:0]      op,
	input  wire logic signed [COORD_W-1:0]   cell_x,
	input  wire logic signed [COORD_W-1:0]   cell_y,
	// result side
	output logic                             done,
	output logic signed      [VAL_W-1:0]     cell_value,
	output logic             [OUT_CNT_W-1:0] cell_hits,
	output logic             [OUT_CNT_W-1:0] cell_misses
);

	logic [CFG_W-1:0] map_width;
	logic [CFG_W-1:0] map_height;
	occ_cmd_t         cmd;
	occ_status_t      status;

	// map size registers: width at 0x0, height at 0x4
	occ_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.map_width  (map_width),
		.map_height (map_height)
	);

	// sequencer: clear sweep, then read / modify / multiply / divide per transaction
	occ_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// counter store, range check, score arithmetic and result registers
	occ_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.op          (op),
		.cell_x      (cell_x),
		.cell_y      (cell_y),
		.map_width   (map_width),
		.map_height  (map_height),
		.done        (done),
		.cell_value  (cell_value),
		.cell_hits   (cell_hits),
		.cell_misses (cell_misses)
	);

`ifndef SYNTH
	// results are never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done strobe held two cycles");

	// a freshly accepted transaction cannot finish in the next cycle
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done) else $error("result right after accept");

	// score stays within its range
	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(cell_value) >= -300 && $signed(cell_value) <= 300))
		else $error("score out of range");

	// untouched cell scores zero
	a_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cell_hits == '0 && cell_misses == '0) |-> (cell_value == '0))
		else $error("untouched cell nonzero score");

	// only misses gives the lowest score
	a_all_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cell_hits == '0 && cell_misses != '0) |-> ($signed(cell_value) == -300))
		else $error("all-miss cell wrong score");
`endif

endmodule

`default_nettype wire

// ===== design/occ_regs.sv =====
`default_nettype none

module occ_regs
	import occ_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready,
	output logic      [CFG_W-1:0]   map_width,
	output logic      [CFG_W-1:0]   map_height
);

	logic wr_en;
	logic reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width  <= MAP_DIM_RESET;
			map_height <= MAP_DIM_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_MAP_WIDTH:  map_width  <= pwdata[CFG_W-1:0];
				REG_MAP_HEIGHT: map_height <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_MAP_WIDTH:  prdata = PDATA_W'(map_width);
			REG_MAP_HEIGHT: prdata = PDATA_W'(map_height);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/occ_ctrl.sv =====
`default_nettype none

module occ_ctrl
	import occ_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire occ_status_t status,
	output occ_cmd_t         cmd,
	output logic             busy
);

	occ_state_t        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              step_last;

	assign step_last = (step_q == STEP_W'(Q_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init)
				step_q <= '0;
			else if (cmd.div_step)
				step_q <= step_q + STEP_W'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start && status.in_range) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				cmd.modify = 1'b1;
				state_d    = ST_MULT;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_DIVINIT;
			end
			ST_DIVINIT: begin
				cmd.div_init = 1'b1;
				state_d      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_last) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== design/occ_datapath.sv =====
`default_nettype none

module occ_datapath
	import occ_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire occ_cmd_t                  cmd,
	output occ_status_t                    status,
	input  wire logic        [OP_W-1:0]    op,
	input  wire logic signed [COORD_W-1:0] cell_x,
	input  wire logic signed [COORD_W-1:0] cell_y,
	input  wire logic        [CFG_W-1:0]   map_width,
	input  wire logic        [CFG_W-1:0]   map_height,
	output logic                           done,
	output logic signed      [VAL_W-1:0]   cell_value,
	output logic             [OUT_CNT_W-1:0] cell_hits,
	output logic             [OUT_CNT_W-1:0] cell_misses
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// counter store: {hits, misses} per cell
	logic [2*COUNT_BITS-1:0] mem [CELL_TOTAL];

	logic [ADDR_W-1:0]       clr_addr_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [OP_W-1:0]         op_q;
	logic [2*COUNT_BITS-1:0] rd_q;
	logic [COUNT_BITS-1:0]   hits_q, misses_q;
	logic [NUM_W-1:0]        num_q;
	logic [DEN_W-1:0]        den_q;
	logic [DEN_W-1:0]        rem_q;
	logic [Q_W-1:0]          nbits_q;
	logic [Q_W-1:0]          quo_q;
	logic                    done_q;

	logic                    x_ok, y_ok;
	logic [ADDR_W-1:0]       addr_d;
	logic [COUNT_BITS-1:0]   rd_hits, rd_misses, hits_d, misses_d;
	logic                    we;
	logic [ADDR_W-1:0]       waddr;
	logic [2*COUNT_BITS-1:0] wdata;
	logic [DEN_W:0]          trial, diff;
	logic                    ge;
	logic [DEN_W-1:0]        rem_d;
	logic [Q_W-1:0]          quo_d;
	logic signed [Q_W:0]     score;

	// range check against min(register, grid)
	assign x_ok = !cell_x[COORD_W-1]
		&& (32'($unsigned(cell_x)) < 32'(map_width))
		&& (32'($unsigned(cell_x)) < GRID_WIDTH);
	assign y_ok = !cell_y[COORD_W-1]
		&& (32'($unsigned(cell_y)) < 32'(map_height))
		&& (32'($unsigned(cell_y)) < GRID_HEIGHT);
	assign status.in_range = x_ok && y_ok;
	assign status.clr_last = (clr_addr_q == ADDR_W'(CELL_TOTAL - 1));

	assign addr_d = ADDR_W'(32'($unsigned(cell_y)) * 32'(GRID_WIDTH)
		+ 32'($unsigned(cell_x)));

	assign rd_hits   = rd_q[2*COUNT_BITS-1:COUNT_BITS];
	assign rd_misses = rd_q[COUNT_BITS-1:0];

	always_comb begin
		hits_d   = rd_hits;
		misses_d = rd_misses;
		unique case (op_q)
			OP_MISS: if (rd_misses != COUNT_MAX) misses_d = rd_misses + COUNT_BITS'(1);
			OP_HIT:  if (rd_hits != COUNT_MAX) hits_d = rd_hits + COUNT_BITS'(1);
			default: ;  // read; unused code reads too
		endcase
	end

	assign we    = cmd.clear || cmd.modify;
	assign waddr = cmd.clear ? clr_addr_q : addr_q;
	assign wdata = cmd.clear ? '0 : {hits_d, misses_d};

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (cmd.rd)
			rd_q <= mem[addr_q];
	end

	// restoring division, one quotient bit per step
	assign trial = {rem_q, nbits_q[Q_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = !diff[DEN_W];
	assign rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
	assign quo_d = {quo_q[Q_W-2:0], ge};
	assign score = $signed({1'b0, quo_d}) - $signed((Q_W+1)'(SCORE_OFFSET));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.clear)
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q <= addr_d;
			op_q   <= op;
		end
		if (cmd.modify) begin
			hits_q   <= hits_d;
			misses_q <= misses_d;
		end
		if (cmd.mult) begin
			num_q <= NUM_W'(hits_q) * NUM_W'(SCORE_SCALE);
			den_q <= DEN_W'(hits_q) + DEN_W'(misses_q);
		end
		if (cmd.div_init) begin
			// quotient fits Q_W bits, so the top part is already below den
			rem_q   <= DEN_W'(num_q[NUM_W-1:Q_W]);
			nbits_q <= num_q[Q_W-1:0];
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q   <= rem_d;
			nbits_q <= {nbits_q[Q_W-2:0], 1'b0};
			quo_q   <= quo_d;
		end
		if (cmd.finish) begin
			cell_value  <= (den_q == '0) ? '0 : score[VAL_W-1:0];
			cell_hits   <= OUT_CNT_W'(hits_q);
			cell_misses <= OUT_CNT_W'(misses_q);
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire
